[sv/ttlp_pkg.sv]
// ----------------------------------------------------------------------------
// ttlp_pkg: shared types and constants for the tap tempo block
// Field widths, register indexes, reset values and the divide-by-1000
// reciprocal used to turn a microsecond gap into whole milliseconds.
// ----------------------------------------------------------------------------
package ttlp_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned HOLD_W  = 26;
  localparam int unsigned PRESS_W = 20;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned LIM_W   = 26;
  localparam int unsigned CFG_W   = 26;
  localparam int unsigned CFG_A_W = 2;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register indexes on the configuration port
  typedef enum logic [CFG_A_W-1:0] {
    REG_HOLD_SAVE = 2'd0,
    REG_MIN_PRESS = 2'd1,
    REG_MIN_IVL   = 2'd2,
    REG_MAX_IVL   = 2'd3
  } ttlp_reg_e;

  localparam logic [LIM_W-1:0]   US_PER_MS     = 26'd1000;
  localparam logic [HOLD_W-1:0]  HOLD_SAVE_RST = 26'd5000000;
  localparam logic [PRESS_W-1:0] MIN_PRESS_RST = 20'd50000;
  // Limits kept in microseconds: min * 1000 and (max + 1) * 1000
  localparam logic [LIM_W-1:0]   MIN_LIM_RST   = 26'd50000;
  localparam logic [LIM_W-1:0]   MAX_LIM_RST   = 26'd2001000;
  localparam logic [IVL_W-1:0]   TEMPO_RST     = 16'd500;

  // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT, exact for x < 2^26
  localparam int unsigned        RECIP_W     = 27;
  localparam int unsigned        RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP       = 27'd68719477;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold_save;
    logic [PRESS_W-1:0] min_press;
    logic [LIM_W-1:0]   min_lim;
    logic [LIM_W-1:0]   max_lim;
  } ttlp_cfg_t;

  typedef struct packed {
    logic              save;
    logic              update;
    logic [LIM_W-1:0]  gap;
  } ttlp_evt_t;

endpackage

[sv/tap_tempo_with_long_press.sv]
// Path: an accepted request passes through the input, event and result
// registers before its result is on m_axis.
// Throughput: one poll per cycle; ready drops only when all three stages are
// full and the result is stalled.
// Reset (rst_ni low, asynchronous): stages empty, no press or tap recorded,
// tempo 500 ms, thresholds 5 s / 50 ms, interval window 50..2000 ms.
// ----------------------------------------------------------------------------
// tap_tempo_with_long_press: tap tempo button with long-press save
// Polls a button with a microsecond timestamp, derives tap intervals and
// raises a save request on a long hold.
// ----------------------------------------------------------------------------
module tap_tempo_with_long_press (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ttlp_pkg::CFG_A_W-1:0]         cfg_addr_i,
  input  logic [ttlp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [0] button_down, [64:1] now_us, [71:65] zero
  input  logic [ttlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] save_pulse, [1] tempo_update, [17:2] tempo_ms, [23:18] zero
  output logic [ttlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  ttlp_pkg::ttlp_cfg_t cfg;
  ttlp_pkg::ttlp_evt_t evt;
  logic                evt_valid;
  logic                evt_ready;

  ttlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ttlp_event u_event (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .evt_valid_o   (evt_valid),
    .evt_ready_i   (evt_ready),
    .evt_o         (evt)
  );

  ttlp_tempo u_tempo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_valid_i   (evt_valid),
    .evt_ready_o   (evt_ready),
    .evt_i         (evt),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A save needs the button held, a tempo update needs a release
  a_save_xor_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("save and tempo update in one result");

  // Input backpressure only when every stage holds a request
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && evt_valid))
    else $error("input stalled with a free stage");

  // Event stage stalls only behind a stalled result
  a_evt_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid && !evt_ready) |-> (m_axis_tvalid && !m_axis_tready))
    else $error("event stage stalled without output backpressure");

endmodule

[sv/ttlp_cfg.sv]
// ----------------------------------------------------------------------------
// ttlp_cfg: configuration registers
// Holds the thresholds and keeps the interval limits prescaled to
// microseconds so the event stage compares raw gaps without dividing.
// ----------------------------------------------------------------------------
module ttlp_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttlp_pkg::CFG_A_W-1:0]        cfg_addr_i,
  input  logic [ttlp_pkg::CFG_W-1:0]          cfg_wdata_i,
  output ttlp_pkg::ttlp_cfg_t                 cfg_o
);

  ttlp_pkg::ttlp_cfg_t cfg_q, cfg_d;
  logic [ttlp_pkg::LIM_W-1:0] ivl_ext;
  logic [ttlp_pkg::LIM_W-1:0] lo_us;
  logic [ttlp_pkg::LIM_W-1:0] hi_us;

  assign ivl_ext = {{(ttlp_pkg::LIM_W - ttlp_pkg::IVL_W){1'b0}},
                    cfg_wdata_i[ttlp_pkg::IVL_W-1:0]};
  assign lo_us   = ivl_ext * ttlp_pkg::US_PER_MS;
  // One past the inclusive maximum, so the upper check is a strict compare
  assign hi_us   = (ivl_ext + {{(ttlp_pkg::LIM_W-1){1'b0}}, 1'b1}) * ttlp_pkg::US_PER_MS;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ttlp_pkg::ttlp_reg_e'(cfg_addr_i))
        ttlp_pkg::REG_HOLD_SAVE: cfg_d.hold_save = cfg_wdata_i[ttlp_pkg::HOLD_W-1:0];
        ttlp_pkg::REG_MIN_PRESS: cfg_d.min_press = cfg_wdata_i[ttlp_pkg::PRESS_W-1:0];
        ttlp_pkg::REG_MIN_IVL:   cfg_d.min_lim   = lo_us;
        ttlp_pkg::REG_MAX_IVL:   cfg_d.max_lim   = hi_us;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_save <= ttlp_pkg::HOLD_SAVE_RST;
      cfg_q.min_press <= ttlp_pkg::MIN_PRESS_RST;
      cfg_q.min_lim   <= ttlp_pkg::MIN_LIM_RST;
      cfg_q.max_lim   <= ttlp_pkg::MAX_LIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/ttlp_event.sv]
// ----------------------------------------------------------------------------
// ttlp_event: input register and button event logic
// Tracks press and tap times, flags save and tempo events and passes the
// tap gap on to the tempo stage.
// ----------------------------------------------------------------------------
module ttlp_event (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ttlp_pkg::ttlp_cfg_t                  cfg_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [ttlp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 evt_valid_o,
  input  logic                                 evt_ready_i,
  output ttlp_pkg::ttlp_evt_t                  evt_o
);

  logic                              in_valid_q;
  logic                              down_q;
  logic [ttlp_pkg::TIME_W-1:0]       now_q;
  logic                              evt_valid_q;
  ttlp_pkg::ttlp_evt_t               evt_q, evt_d;

  logic                              was_down_q;
  logic [ttlp_pkg::TIME_W-1:0]       press_time_q;
  logic                              saved_q;
  logic [ttlp_pkg::TIME_W-1:0]       last_tap_q;
  logic                              last_valid_q;

  logic                              mid_ready;
  logic                              in_ready;
  logic                              fire;
  logic [ttlp_pkg::TIME_W-1:0]       held;
  logic [ttlp_pkg::TIME_W-1:0]       gap;
  logic                              rising, holding, falling;
  logic                              hold_reached, long_enough, is_tap, in_range;

  assign mid_ready     = !evt_valid_q || evt_ready_i;
  assign in_ready      = !in_valid_q || mid_ready;
  assign s_axis_tready = in_ready;
  assign fire          = in_valid_q && mid_ready;

  assign held = now_q - press_time_q;
  assign gap  = now_q - last_tap_q;

  assign rising  = down_q && !was_down_q;
  assign holding = down_q && was_down_q;
  assign falling = !down_q && was_down_q;

  assign hold_reached = (|held[ttlp_pkg::TIME_W-1:ttlp_pkg::HOLD_W]) ||
                        (held[ttlp_pkg::HOLD_W-1:0] >= cfg_i.hold_save);
  assign long_enough  = (|held[ttlp_pkg::TIME_W-1:ttlp_pkg::PRESS_W]) ||
                        (held[ttlp_pkg::PRESS_W-1:0] > cfg_i.min_press);
  assign is_tap       = falling && !hold_reached && long_enough;
  // Full-width gap: anything at or above 2^26 us is out of range
  assign in_range     = !(|gap[ttlp_pkg::TIME_W-1:ttlp_pkg::LIM_W]) &&
                        (gap[ttlp_pkg::LIM_W-1:0] >= cfg_i.min_lim) &&
                        (gap[ttlp_pkg::LIM_W-1:0] <  cfg_i.max_lim);

  always_comb begin
    evt_d.save   = holding && hold_reached && !saved_q;
    evt_d.update = is_tap && last_valid_q && in_range;
    evt_d.gap    = gap[ttlp_pkg::LIM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      evt_valid_q  <= 1'b0;
      was_down_q   <= 1'b0;
      press_time_q <= '0;
      saved_q      <= 1'b0;
      last_tap_q   <= '0;
      last_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (mid_ready) begin
        evt_valid_q <= in_valid_q;
      end
      if (fire) begin
        was_down_q <= down_q;
        if (rising) begin
          press_time_q <= now_q;
          saved_q      <= 1'b0;
        end
        if (evt_d.save) begin
          saved_q <= 1'b1;
        end
        if (is_tap) begin
          last_tap_q   <= now_q;
          last_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      down_q <= s_axis_tdata[0];
      now_q  <= s_axis_tdata[ttlp_pkg::TIME_W:1];
    end
    if (fire) begin
      evt_q <= evt_d;
    end
  end

  assign evt_valid_o = evt_valid_q;
  assign evt_o       = evt_q;

endmodule

[sv/ttlp_tempo.sv]
// ----------------------------------------------------------------------------
// ttlp_tempo: tempo register and result register
// Converts the tap gap to milliseconds by reciprocal multiply, keeps the
// current tempo and drives the result stream.
// ----------------------------------------------------------------------------
module ttlp_tempo (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 evt_valid_i,
  output logic                                 evt_ready_o,
  input  ttlp_pkg::ttlp_evt_t                  evt_i,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [ttlp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned PROD_W = ttlp_pkg::LIM_W + ttlp_pkg::RECIP_W;

  logic                                  out_valid_q;
  logic [ttlp_pkg::OUT_TDATA_W-1:0]      out_data_q;
  logic [ttlp_pkg::IVL_W-1:0]            tempo_q;
  logic [ttlp_pkg::IVL_W-1:0]            tempo_d;
  logic [PROD_W-1:0]                     prod;
  logic                                  ready;
  logic                                  take;

  assign ready       = !out_valid_q || m_axis_tready;
  assign evt_ready_o = ready;
  assign take        = evt_valid_i && ready;

  assign prod = {{ttlp_pkg::RECIP_W{1'b0}}, evt_i.gap} *
                {{ttlp_pkg::LIM_W{1'b0}}, ttlp_pkg::RECIP};

  // An in-range gap is below 65536 ms, so the low 16 quotient bits are exact
  assign tempo_d = evt_i.update ? prod[ttlp_pkg::RECIP_SHIFT +: ttlp_pkg::IVL_W] : tempo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      tempo_q     <= ttlp_pkg::TEMPO_RST;
    end else begin
      if (ready) begin
        out_valid_q <= evt_valid_i;
      end
      if (take) begin
        tempo_q <= tempo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= {{(ttlp_pkg::OUT_TDATA_W - ttlp_pkg::IVL_W - 2){1'b0}},
                     tempo_d, evt_i.update, evt_i.save};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[dv/tempo_check_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tempo_check_pkg: expected-result tracking for the tap tempo block
// Keeps a cycle-free copy of the button, tap and tempo state, works out the
// result of every accepted poll and matches it against the output stream.
// ----------------------------------------------------------------------------
package tempo_check_pkg;

  import ttlp_pkg::*;

  typedef struct packed {
    logic        save;
    logic        update;
    logic [15:0] tempo;
  } tempo_res_t;

  class tempo_scoreboard;
    // register copies
    logic [25:0] hold_us;
    logic [19:0] press_min_us;
    logic [15:0] ivl_lo_ms;
    logic [15:0] ivl_hi_ms;

    // button and tap state
    bit          btn_held;
    logic [63:0] press_t;
    bit          hold_saved;
    logic [63:0] tap_t;
    bit          tap_seen;
    logic [15:0] tempo;

    tempo_res_t  tempo_q[$];

    int unsigned errors;
    int unsigned reported;
    int unsigned saves;
    int unsigned updates;
    int unsigned taps;
    int unsigned rejected;

    function new();
      hold_us      = HOLD_SAVE_RST;
      press_min_us = MIN_PRESS_RST;
      ivl_lo_ms    = 16'd50;
      ivl_hi_ms    = 16'd2000;
      btn_held     = 1'b0;
      press_t      = '0;
      hold_saved   = 1'b0;
      tap_t        = '0;
      tap_seen     = 1'b0;
      tempo        = TEMPO_RST;
      errors       = 0;
      reported     = 0;
      saves        = 0;
      updates      = 0;
      taps         = 0;
      rejected     = 0;
    endfunction

    function void set_reg(ttlp_reg_e idx, logic [25:0] val);
      case (idx)
        REG_HOLD_SAVE: hold_us      = val;
        REG_MIN_PRESS: press_min_us = val[19:0];
        REG_MIN_IVL:   ivl_lo_ms    = val[15:0];
        REG_MAX_IVL:   ivl_hi_ms    = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return tempo_q.size();
    endfunction

    // Advance the button state by one accepted poll and queue its result.
    function void note_poll(bit down, logic [63:0] now);
      tempo_res_t  res;
      logic [63:0] held;
      logic [63:0] gap_ms;
      res.save   = 1'b0;
      res.update = 1'b0;
      if (down && !btn_held) begin
        press_t    = now;
        hold_saved = 1'b0;
      end else if (down && btn_held) begin
        held = now - press_t;
        if (held >= hold_us && !hold_saved) begin
          res.save   = 1'b1;
          hold_saved = 1'b1;
          saves++;
        end
      end else if (!down && btn_held) begin
        held = now - press_t;
        if (held < hold_us && held > press_min_us) begin
          taps++;
          if (tap_seen) begin
            // full 64-bit quotient, so a huge gap never folds into the window
            gap_ms = (now - tap_t) / 64'd1000;
            if (gap_ms >= ivl_lo_ms && gap_ms <= ivl_hi_ms) begin
              tempo      = gap_ms[15:0];
              res.update = 1'b1;
              updates++;
            end else begin
              rejected++;
            end
          end
          tap_t    = now;
          tap_seen = 1'b1;
        end
      end
      btn_held  = down;
      res.tempo = tempo;
      tempo_q.push_back(res);
    endfunction

    function void check_result(logic [23:0] data);
      tempo_res_t want;
      tempo_res_t got;
      got.save   = data[0];
      got.update = data[1];
      got.tempo  = data[17:2];
      if (tempo_q.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("tempo result without a pending poll: save=%0d update=%0d tempo=%0d",
                   got.save, got.update, got.tempo);
        reported++;
        return;
      end
      want = tempo_q.pop_front();
      if (got.save != want.save || got.update != want.update || got.tempo != want.tempo)
      begin
        errors++;
        if (reported < 10)
          $display("tempo result mismatch: expected save=%0d update=%0d tempo=%0d, got save=%0d update=%0d tempo=%0d",
                   want.save, want.update, want.tempo, got.save, got.update, got.tempo);
        reported++;
      end
    endfunction
  endclass

endpackage

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for tap_tempo_with_long_press
// Feeds button polls with timestamps through the input stream, walks several
// register settings and checks every result against a running prediction,
// with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module tb;

  import ttlp_pkg::*;
  import tempo_check_pkg::*;

  localparam int unsigned POLLS_PER_SETTING = 160;
  localparam int unsigned SQUEEZE_CYCLES    = 64;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_A_W-1:0]     cfg_addr_i    = '0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [0] button_down, [64:1] now_us, [71:65] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] save_pulse, [1] tempo_update, [17:2] tempo_ms, [23:18] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  tempo_scoreboard sb;

  int unsigned polls_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned settings_used = 1;
  int unsigned squeezed      = 0;
  int unsigned burst_left    = 0;
  bit          flood         = 1'b0;
  logic [63:0] tap_anchor    = '0;

  tap_tempo_with_long_press i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stall stretches, plus long squeezes that back up the pipe
  initial begin
    int unsigned next_squeeze;
    int unsigned seg;
    int unsigned mode;
    next_squeeze = 250;
    forever begin
      if (results_seen >= next_squeeze) begin
        flood = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeezed += SQUEEZE_CYCLES;
        flood = 1'b0;
        next_squeeze += 400;
      end
      seg  = $urandom_range(4, 40);
      mode = $urandom_range(0, 4);
      if (mode == 4) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(15, 40)) @(posedge clk_i);
      end else begin
        repeat (seg) begin
          case (mode)
            1:       m_axis_tready <= ($urandom % 3 != 0);
            2:       m_axis_tready <= ($urandom % 8 == 0);
            default: m_axis_tready <= 1'b1;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        results_seen++;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (flood) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom % 40 == 0) burst_left = $urandom_range(20, 60);
    r = $urandom % 100;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  task automatic send_poll(bit down, logic [63:0] stamp);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, stamp, down};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_poll(down, stamp);
    polls_sent++;
  endtask

  task automatic drain_polls();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(ttlp_reg_e idx, logic [25:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [25:0] hold, logic [25:0] press,
                               logic [25:0] lo, logic [25:0] hi);
    drain_polls();
    write_reg(REG_HOLD_SAVE, hold);
    write_reg(REG_MIN_PRESS, press);
    write_reg(REG_MIN_IVL, lo);
    write_reg(REG_MAX_IVL, hi);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Press and release with the duration and tap spacing aimed at the thresholds.
  task automatic tap_gesture();
    logic [63:0] dur;
    logic [63:0] gap_us;
    logic [63:0] lo_us;
    logic [63:0] hi_us;
    logic [63:0] rel_t;
    logic [63:0] prs_t;
    int unsigned n;
    lo_us = sb.ivl_lo_ms * 1000;
    hi_us = sb.ivl_hi_ms * 1000;
    case ($urandom % 6)
      0:       dur = sb.press_min_us;
      1:       dur = sb.press_min_us + 1;
      2:       dur = sb.hold_us - 1;
      3:       dur = sb.hold_us;
      4:       dur = sb.press_min_us + 1 + $urandom_range(0, 400000);
      default: dur = $urandom_range(0, 134217726);
    endcase
    case ($urandom % 7)
      0:       gap_us = lo_us - 1;
      1:       gap_us = lo_us;
      2:       gap_us = hi_us + 999;
      3:       gap_us = hi_us + 1000;
      4:       gap_us = {$urandom, $urandom};
      default: begin
        if (hi_us + 1000 > lo_us)
          gap_us = lo_us + ({$urandom, $urandom} % (hi_us + 1000 - lo_us));
        else
          gap_us = lo_us + $urandom_range(0, 1000000);
      end
    endcase
    rel_t = tap_anchor + gap_us;
    prs_t = rel_t - dur;
    if (sb.btn_held || ($urandom % 2 == 0))
      send_poll(1'b0, prs_t - $urandom_range(1, 1000));
    send_poll(1'b1, prs_t);
    n = $urandom_range(0, 3);
    repeat (n) send_poll(1'b1, prs_t + ((dur == 0) ? 64'd0 : ({$urandom, $urandom} % dur)));
    send_poll(1'b0, rel_t);
    tap_anchor = rel_t;
  endtask

  // Hold straddling the save threshold, then release.
  task automatic hold_gesture();
    logic [63:0] t0;
    logic [63:0] h;
    h  = sb.hold_us;
    t0 = tap_anchor + $urandom_range(1, 5000000);
    if (sb.btn_held) send_poll(1'b0, t0 - 1);
    send_poll(1'b1, t0);
    if (h > 0) send_poll(1'b1, t0 + h - 1);
    send_poll(1'b1, t0 + h);
    send_poll(1'b1, t0 + h + $urandom_range(0, 1000000));
    send_poll(1'b0, t0 + h + $urandom_range(1000000, 2000000));
    tap_anchor = t0 + h + 2000000;
  endtask

  task automatic noise_poll();
    logic [63:0] t;
    if ($urandom % 2) t = {$urandom, $urandom};
    else              t = tap_anchor + $urandom_range(0, 100000);
    send_poll($urandom % 2, t);
  endtask

  task automatic random_polls(int unsigned count);
    int unsigned stop_at;
    int unsigned r;
    stop_at = polls_sent + count;
    if ($urandom % 4 == 0) tap_anchor = ~64'd0 - $urandom_range(0, 200000000);
    else                   tap_anchor = {$urandom, $urandom};
    while (polls_sent < stop_at) begin
      r = $urandom % 10;
      if (r < 6)      tap_gesture();
      else if (r < 8) hold_gesture();
      else            noise_poll();
    end
  endtask

  task automatic directed_polls();
    logic [63:0] far_t;
    // long hold: save exactly at the threshold and only once
    send_poll(1'b0, 64'd0);
    send_poll(1'b1, 64'd0);
    send_poll(1'b1, 64'd4_999_999);
    send_poll(1'b1, 64'd5_000_000);
    send_poll(1'b1, 64'd9_000_000);
    send_poll(1'b0, 64'd9_000_001);
    // first tap only records its time
    send_poll(1'b1, 64'd20_000_000);
    send_poll(1'b0, 64'd20_050_001);
    // press exactly at the minimum is too short
    send_poll(1'b1, 64'd21_000_000);
    send_poll(1'b0, 64'd21_050_000);
    // interval at the top of the window, then one past it
    send_poll(1'b1, 64'd22_000_000);
    send_poll(1'b0, 64'd22_051_000);
    send_poll(1'b1, 64'd24_000_000);
    send_poll(1'b0, 64'd24_052_000);
    // bottom of the window, press stamped before the last tap
    send_poll(1'b1, 64'd24_042_000);
    send_poll(1'b0, 64'd24_102_000);
    // quotient that would fall in range if cut to 32 bits
    far_t = 64'd24_102_000 + 64'd4_294_967_396 * 64'd1000;
    send_poll(1'b1, far_t - 64'd100_000);
    send_poll(1'b0, far_t);
    // tap at the top timestamp, next one across the wrap
    send_poll(1'b1, ~64'd0 - 64'd100_000);
    send_poll(1'b0, ~64'd0);
    send_poll(1'b1, 64'd100_000);
    send_poll(1'b0, 64'd899_999);
    // timestamp running backwards during a hold
    send_poll(1'b1, 64'd5_000_000);
    send_poll(1'b1, 64'd1_000);
    send_poll(1'b0, 64'd2_000);
  endtask

  initial begin
    logic [25:0] lo;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_polls();
    random_polls(POLLS_PER_SETTING);

    apply_setting(26'd67108863, 26'd0, 26'd1, 26'd65535);
    random_polls(POLLS_PER_SETTING);
    apply_setting(26'd67108863, 26'd1048575, 26'd65535, 26'd65535);
    random_polls(POLLS_PER_SETTING);
    apply_setting(26'd1, 26'd0, 26'd1, 26'd1);
    random_polls(POLLS_PER_SETTING);
    // crossed window: nothing may be accepted
    apply_setting(26'd3000000, 26'd20000, 26'd500, 26'd100);
    random_polls(POLLS_PER_SETTING);
    // zero save threshold: the first held poll after each press saves, no taps
    apply_setting(26'd0, 26'd0, 26'd1, 26'd65535);
    random_polls(POLLS_PER_SETTING);
    lo = $urandom_range(1, 200);
    apply_setting($urandom_range(200000, 3000000), $urandom_range(0, 100000),
                  lo, $urandom_range(lo, 3000));
    random_polls(POLLS_PER_SETTING);

    drain_polls();
    repeat (6) @(posedge clk_i);
    $display("Ran %0d polls over %0d register settings, %0d cycles of forced output stall.",
             polls_sent, settings_used, squeezed);
    $display("Saw %0d taps, %0d tempo changes, %0d out-of-window intervals, %0d save requests.",
             sb.taps, sb.updates, sb.rejected, sb.saves);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
